// ----- design/cps_pkg.sv -----
// Package of shared types and constants for the counter priority task scheduler.
`default_nettype none

package cps_pkg;

    // Result field widths, fixed by the stream format.
    localparam int unsigned PRIO_IN_W  = 8;
    localparam int unsigned RSTATE_W   = 2;
    localparam int unsigned RSLOT_W    = 4;
    localparam int unsigned QCOUNT_W   = 5;
    localparam int unsigned RESULT_W   = RSTATE_W + RSLOT_W + 3 + QCOUNT_W;
    localparam int unsigned OUT_DATA_W = 16;

    // Codes of the running state.
    localparam logic [RSTATE_W-1:0] RUN_NONE = 2'd0;
    localparam logic [RSTATE_W-1:0] RUN_IDLE = 2'd1;
    localparam logic [RSTATE_W-1:0] RUN_TASK = 2'd2;

    // Input kind codes.
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;        // an input transfer happens in this cycle
        logic rd_cur;        // read the tables at the current slot
        logic dec;           // write back the current counter minus one
        logic set_switched;  // this tick schedules
        logic set_idle;      // select the idle task
        logic scan_start;    // clear the scan index and the running maximum
        logic scan_rd;       // read the tables at the scan index and advance it
        logic reload_mode;   // the issued read reloads the counter from the priority
        logic set_reloaded;  // mark that the counters are refilled
        logic commit;        // make the best slot the current task
        logic load_out;      // load the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cur_live;      // a real task runs and its counter is nonzero
        logic empty;         // no task is queued
        logic idx_last;      // the scan index sits on the last queued slot
        logic max_zero;      // the maximum counter found is zero
        logic out_free;      // the output register can take a result
    } t_status;

endpackage

`default_nettype wire

// ----- design/cps_ctrl.sv -----
// Controller state machine that sequences add, decrement, scan and reload steps.
`default_nettype none

module cps_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_kind,
    output logic             o_in_ready,
    input  cps_pkg::t_status i_status,
    output cps_pkg::t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE       = 10'b00_0000_0001,
        ST_RDCUR      = 10'b00_0000_0010,
        ST_DECIDE     = 10'b00_0000_0100,
        ST_SCAN       = 10'b00_0000_1000,
        ST_SCAN_END   = 10'b00_0001_0000,
        ST_CHECK      = 10'b00_0010_0000,
        ST_RELOAD     = 10'b00_0100_0000,
        ST_RELOAD_END = 10'b00_1000_0000,
        ST_COMMIT     = 10'b01_0000_0000,
        ST_FIN        = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == cps_pkg::KIND_TICK) begin
                        n_state = ST_RDCUR;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_RDCUR: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_status.cur_live) begin
                    o_cmd.dec = 1'b1;
                    n_state   = ST_FIN;
                end else begin
                    o_cmd.set_switched = 1'b1;
                    if (i_status.empty) begin
                        o_cmd.set_idle = 1'b1;
                        n_state        = ST_FIN;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.max_zero) begin
                    o_cmd.set_reloaded = 1'b1;
                    o_cmd.scan_start   = 1'b1;
                    n_state            = ST_RELOAD;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_FIN;
                end
            end
            ST_RELOAD: begin
                o_cmd.scan_rd     = 1'b1;
                o_cmd.reload_mode = 1'b1;
                if (i_status.idx_last) begin
                    n_state = ST_RELOAD_END;
                end
            end
            ST_RELOAD_END: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/cps_datapath.sv -----
// Datapath with the priority and counter tables, scan logic and result register.
`default_nettype none

module cps_datapath #(
    parameter int unsigned MAX_TASKS = 16,
    parameter int unsigned PRIO_BITS = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  cps_pkg::t_cmd                        i_cmd,
    input  wire                                  i_kind,
    input  wire  [cps_pkg::PRIO_IN_W-1:0]        i_prio,
    output cps_pkg::t_status                     o_status,
    input  wire                                  i_out_ready,
    output logic                                 o_out_valid,
    output logic [cps_pkg::RESULT_W-1:0]         o_out_data
);

    localparam int unsigned SLOT_W = $clog2(MAX_TASKS);
    localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);

    logic [PRIO_BITS-1:0] prio_mem [MAX_TASKS];
    logic [PRIO_BITS-1:0] cnt_mem  [MAX_TASKS];

    logic [CNT_W-1:0]             r_task_count;
    logic [cps_pkg::RSTATE_W-1:0] r_cur_state;
    logic [SLOT_W-1:0]            r_cur_slot;
    logic [SLOT_W-1:0]            r_idx;
    logic [PRIO_BITS-1:0]         r_rd_cnt;
    logic [PRIO_BITS-1:0]         r_rd_prio;
    logic                         r_cmp_vld;
    logic                         r_cmp_prio;
    logic [SLOT_W-1:0]            r_cmp_idx;
    logic [PRIO_BITS-1:0]         r_max;
    logic [SLOT_W-1:0]            r_best;
    logic                         r_switched;
    logic                         r_reloaded;
    logic                         r_rejected;
    logic                         r_out_valid;
    logic [cps_pkg::RESULT_W-1:0] r_out_data;

    logic [39:0]          prio_ext;
    logic [PRIO_BITS-1:0] prio_in;
    logic                 full;
    logic                 do_add;
    logic [SLOT_W-1:0]    add_slot;
    logic [SLOT_W-1:0]    rd_addr;
    logic [PRIO_BITS-1:0] cmp_val;
    logic [31:0]          slot_ext;
    logic [31:0]          count_ext;
    logic [cps_pkg::RSLOT_W-1:0] out_slot;

    // The priority is masked to the configured width.
    assign prio_ext = 40'(i_prio);
    assign prio_in  = prio_ext[PRIO_BITS-1:0];
    assign full     = (r_task_count == CNT_W'(MAX_TASKS));
    assign do_add   = i_cmd.accept && (i_kind == cps_pkg::KIND_ADD) && !full;
    assign add_slot = r_task_count[SLOT_W-1:0];
    assign rd_addr  = i_cmd.rd_cur ? r_cur_slot : r_idx;
    assign cmp_val  = r_cmp_prio ? r_rd_prio : r_rd_cnt;

    // Table memories: one write port each and a registered read.
    always_ff @(posedge i_clk) begin
        if (do_add) begin
            prio_mem[add_slot] <= prio_in;
        end
        r_rd_prio <= prio_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (do_add) begin
            cnt_mem[add_slot] <= prio_in;
        end else if (i_cmd.dec) begin
            cnt_mem[r_cur_slot] <= r_rd_cnt - 1'b1;
        end else if (r_cmp_vld && r_cmp_prio) begin
            cnt_mem[r_cmp_idx] <= r_rd_prio;
        end
        r_rd_cnt <= cnt_mem[rd_addr];
    end

    // Scan index and the compare stage, which acts in the cycle after the read.
    always_ff @(posedge i_clk) begin
        r_cmp_prio <= i_cmd.reload_mode;
        r_cmp_idx  <= r_idx;
        if (i_cmd.scan_start) begin
            r_idx  <= '0;
            r_max  <= '0;
            r_best <= '0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_cmp_vld && (cmp_val >= r_max)) begin
                r_max  <= cmp_val;
                r_best <= r_cmp_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld    <= 1'b0;
            r_task_count <= '0;
            r_cur_state  <= cps_pkg::RUN_NONE;
            r_cur_slot   <= '0;
            r_switched   <= 1'b0;
            r_reloaded   <= 1'b0;
            r_rejected   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.accept) begin
                r_switched <= 1'b0;
                r_reloaded <= 1'b0;
                r_rejected <= (i_kind == cps_pkg::KIND_ADD) && full;
            end
            if (do_add) begin
                r_task_count <= r_task_count + 1'b1;
            end
            if (i_cmd.set_switched) begin
                r_switched <= 1'b1;
            end
            if (i_cmd.set_reloaded) begin
                r_reloaded <= 1'b1;
            end
            if (i_cmd.set_idle) begin
                r_cur_state <= cps_pkg::RUN_IDLE;
                r_cur_slot  <= '0;
            end else if (i_cmd.commit) begin
                r_cur_state <= cps_pkg::RUN_TASK;
                r_cur_slot  <= r_best;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign slot_ext  = 32'(r_cur_slot);
    assign count_ext = 32'(r_task_count);
    assign out_slot  = (r_cur_state == cps_pkg::RUN_TASK) ?
                       slot_ext[cps_pkg::RSLOT_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {count_ext[cps_pkg::QCOUNT_W-1:0], r_rejected, r_reloaded,
                           r_switched, out_slot, r_cur_state};
        end
    end

    assign o_status.cur_live = (r_cur_state == cps_pkg::RUN_TASK) &&
                               (CNT_W'(r_cur_slot) < r_task_count) &&
                               (r_rd_cnt != '0);
    assign o_status.empty    = (r_task_count == '0);
    assign o_status.idx_last = (CNT_W'(r_idx) == (r_task_count - 1'b1));
    assign o_status.max_zero = (r_max == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- design/counter_priority_task_scheduler.sv -----
// Top level of the counter priority task scheduler with one run queue.
//
// The slave stream carries one item per transfer: tuser holds the kind (add a
// task or timer tick) and tdata holds the priority of an added task. Every
// item yields exactly one result on the master stream, which reports the
// running task, whether the tick scheduled, whether counters were reloaded,
// whether an add was refused and how many tasks are queued.
// A tick that only decrements the running task's counter reads it and writes
// it back. A tick that schedules scans every queued slot once through the
// single read port of the counter table, and a second pass reloads the
// counters from their priorities when all counters are zero. One item is
// worked on at a time.
// The result waits in an output register; the next item is taken while it
// waits, but its own result is held back until the receiver takes the first.
// A stalled receiver therefore stops the block only after one further item.
// Reset is synchronous and active low: it empties the queue and leaves
// nothing running. The table contents are not cleared; only the contents of
// written slots are ever used.
`default_nettype none

module counter_priority_task_scheduler #(
    parameter int unsigned MAX_TASKS = 16,
    parameter int unsigned PRIO_BITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Slave stream of input items.
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] prio
    input  wire  [0:0]  i_s_axis_tuser,   // [0] kind
    // Master stream of results.
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [1:0] running_state, [5:2] running_slot,
                                          // [6] switched, [7] reloaded,
                                          // [8] add_rejected, [13:9] queued_count
);

    cps_pkg::t_cmd    cmd;
    cps_pkg::t_status status;
    logic [cps_pkg::RESULT_W-1:0] out_data;

    // The controller decides the sequence of steps for each item.
    cps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser[0]),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath owns the tables, the scan and the result register.
    cps_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .PRIO_BITS (PRIO_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_s_axis_tuser[0]),
        .i_prio      (i_s_axis_tdata),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (out_data)
    );

    // The result is padded with zeros to whole bytes.
    assign o_m_axis_tdata = {{(cps_pkg::OUT_DATA_W - cps_pkg::RESULT_W){1'b0}}, out_data};

endmodule

`default_nettype wire
